### sv/upx2_pkg.sv
package upx2_pkg;

    // pixel format codes
    localparam logic [2:0] FMT_PLANE8 = 3'd0;
    localparam logic [2:0] FMT_YUY2   = 3'd1;
    localparam logic [2:0] FMT_RGB555 = 3'd2;
    localparam logic [2:0] FMT_RGB565 = 3'd3;
    localparam logic [2:0] FMT_RGB24  = 3'd4;
    localparam logic [2:0] FMT_RGB32  = 3'd5;

    // color field masks
    localparam logic [31:0] MASK_555_R = 32'h0000_7c00;
    localparam logic [31:0] MASK_555_G = 32'h0000_03e0;
    localparam logic [31:0] MASK_BLUE  = 32'h0000_001f;
    localparam logic [31:0] MASK_565_R = 32'h0000_f800;
    localparam logic [31:0] MASK_565_G = 32'h0000_07e0;

    // line store geometry: even destination row, two words per entry
    localparam int STORE_WORDS = 4096;
    localparam int STORE_PAIRS = STORE_WORDS / 2;

    // destination coordinate width
    localparam int COORD_W = 12;

    // emit step codes: two vertical, two even row, two copy row
    localparam logic [2:0] STEP_FIRST_VERT = 3'd0;
    localparam logic [2:0] STEP_FIRST_EVEN = 3'd2;
    localparam logic [2:0] STEP_LAST_EVEN  = 3'd3;
    localparam logic [2:0] STEP_LAST_COPY  = 3'd5;

    // emit phase codes
    localparam logic [1:0] PH_VERT = 2'd0;
    localparam logic [1:0] PH_EVEN = 2'd1;
    localparam logic [1:0] PH_COPY = 2'd2;

    typedef struct packed {
        logic [31:0] pixel_word;
        logic        last_in_row;
        logic        final_row;
    } pixel_in_t;

    typedef struct packed {
        logic [31:0]        out_word;
        logic [COORD_W-1:0] out_row;
        logic [COORD_W-1:0] out_col;
        logic               last_of_run;
    } pixel_out_t;

    function automatic logic [31:0] fmt_mask(input logic [2:0] f);
        logic [31:0] m;
        case (f) inside
            FMT_PLANE8:             m = 32'h0000_00ff;
            FMT_RGB555, FMT_RGB565: m = 32'h0000_ffff;
            FMT_RGB24:              m = 32'h00ff_ffff;
            default:                m = 32'hffff_ffff;
        endcase
        return m;
    endfunction

    // truncating average of all four bytes
    function automatic logic [31:0] avg_bytes4(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] r;
        logic [8:0]  s;
        r = '0;
        for (int i = 0; i < 4; i++) begin
            s = {1'b0, a[8*i +: 8]} + {1'b0, b[8*i +: 8]};
            r[8*i +: 8] = s[8:1];
        end
        return r;
    endfunction

    function automatic logic [31:0] avg_fields(input logic [31:0] a, input logic [31:0] b,
                                               input logic [31:0] m0, input logic [31:0] m1,
                                               input logic [31:0] m2);
        logic [31:0] s0;
        logic [31:0] s1;
        logic [31:0] s2;
        s0 = (a & m0) + (b & m0);
        s1 = (a & m1) + (b & m1);
        s2 = (a & m2) + (b & m2);
        return ((s0 >> 1) & m0) | ((s1 >> 1) & m1) | ((s2 >> 1) & m2);
    endfunction

    function automatic logic [31:0] even_word(input logic [2:0] f, input logic [31:0] a);
        logic [8:0] s;
        s = {1'b0, a[7:0]} + {1'b0, a[23:16]};
        if (f == FMT_YUY2)
            return {a[31:24], s[8:1], a[15:8], a[7:0]};
        return a;
    endfunction

    function automatic logic [31:0] odd_word(input logic [2:0] f, input logic [31:0] a,
                                             input logic [31:0] b);
        logic [31:0] ab;
        logic [8:0]  sy;
        ab = avg_bytes4(a, b);
        sy = {1'b0, a[23:16]} + {1'b0, b[7:0]};
        case (f)
            FMT_PLANE8: return ab & 32'h0000_00ff;
            FMT_YUY2:   return {ab[31:24], sy[8:1], ab[15:8], a[23:16]};
            FMT_RGB555: return avg_fields(a, b, MASK_555_R, MASK_555_G, MASK_BLUE);
            FMT_RGB565: return avg_fields(a, b, MASK_565_R, MASK_565_G, MASK_BLUE);
            FMT_RGB24:  return ab & 32'h00ff_ffff;
            default:    return ab;
        endcase
    endfunction

    // row end: yuy2 repeats the second luma sample
    function automatic logic [31:0] end_word(input logic [2:0] f, input logic [31:0] a);
        if (f == FMT_YUY2)
            return {a[31:24], a[23:16], a[15:8], a[23:16]};
        return a;
    endfunction

    function automatic logic [31:0] vert_avg(input logic [2:0] f, input logic [31:0] a,
                                             input logic [31:0] b);
        case (f)
            FMT_RGB555: return avg_fields(a, b, MASK_555_R, MASK_555_G, MASK_BLUE);
            FMT_RGB565: return avg_fields(a, b, MASK_565_R, MASK_565_G, MASK_BLUE);
            default:    return avg_bytes4(a, b);
        endcase
    endfunction

endpackage

### sv/upx2_ram.sv
module upx2_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read returns the old contents on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### sv/pixel_upscale_2x_interpolate.sv
// A request's pairs pass through the job slots, the fetch stage and the emit stage, which drives the output.
// Throughput: one result per cycle at the output port; a mid-row request gives up to six
// results, four on an inner row, a row-end request up to twelve; the output port sets it.
// Each pair reads and rewrites one line store entry in the same cycle (read-first port).
// Reset: asynchronous, active low; clears format, counters and pipeline valids.
// The line store is not cleared; no start-up delay after reset.
module pixel_upscale_2x_interpolate
    import upx2_pkg::*;
#(
    parameter int MAX_SRC_WIDTH  = 2048,
    parameter int MAX_SRC_HEIGHT = 2048
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [2:0] cfg_wdata,
    input  logic       in_valid,
    output logic       in_ready,
    input  pixel_in_t  in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output pixel_out_t out_data
);

    localparam int COL_W      = $clog2(MAX_SRC_WIDTH);
    localparam int ROW_W      = (MAX_SRC_HEIGHT > 1) ? $clog2(MAX_SRC_HEIGHT) : 1;
    localparam int PAIR_DEPTH = (MAX_SRC_WIDTH < STORE_PAIRS) ? MAX_SRC_WIDTH : STORE_PAIRS;
    localparam int ADDR_W     = $clog2(PAIR_DEPTH);
    localparam logic [COL_W:0] COL_LIMIT = (COL_W + 1)'(MAX_SRC_WIDTH);
    localparam logic [ROW_W:0] ROW_LIMIT = (ROW_W + 1)'(MAX_SRC_HEIGHT);
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(MAX_SRC_WIDTH - 1);

    // one destination column pair and the rows it lands on
    typedef struct packed {
        logic [31:0]      od;
        logic [31:0]      ev;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             fin;
        logic             last_job;
    } job_t;

    logic [2:0]       fmt_reg;
    logic [31:0]      prev_word_reg, prev_word_next;
    logic             have_prev_reg, have_prev_next;
    logic [COL_W-1:0] src_col_reg, src_col_next;
    logic [ROW_W-1:0] src_row_reg, src_row_next;

    logic             a_valid_reg, a_valid_next;
    logic             b_valid_reg, b_valid_next;
    job_t             a_job_reg, b_job_reg;
    logic             f_valid_reg, f_valid_next;
    job_t             f_job_reg;
    logic             e_valid_reg, e_valid_next;
    logic [2:0]       e_step_reg, e_step_next;
    job_t             e_job_reg;
    logic [31:0]      e_va0_reg, e_va1_reg;

    logic             in_fire;
    logic             pop;
    job_t             pop_job;
    logic             f_to_e;
    logic             e_done;
    logic [2:0]       e_end;
    logic [2:0]       f_start;
    logic [31:0]      cur_word;
    logic [COL_W:0]   col_inc;
    logic [ROW_W:0]   row_inc;
    logic [COL_W-1:0] prev_col;
    job_t             new_a, new_b;
    logic [63:0]      ram_rdata;
    logic [ADDR_W-1:0] pop_addr;

    // format register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg <= FMT_PLANE8;
        end
        else if (cfg_we)
        begin
            fmt_reg <= cfg_wdata;
        end
    end

    // pair jobs formed from the incoming word
    always_comb
    begin
        cur_word = in_data.pixel_word & fmt_mask(fmt_reg);
        col_inc  = {1'b0, src_col_reg} + 1'b1;
        row_inc  = {1'b0, src_row_reg} + 1'b1;
        prev_col = (src_col_reg == '0) ? COL_LAST : src_col_reg - 1'b1;

        new_a.ev       = even_word(fmt_reg, prev_word_reg);
        new_a.od       = odd_word(fmt_reg, prev_word_reg, cur_word);
        new_a.col      = prev_col;
        new_a.row      = src_row_reg;
        new_a.fin      = in_data.final_row;
        new_a.last_job = !in_data.last_in_row;

        new_b.ev       = even_word(fmt_reg, cur_word);
        new_b.od       = end_word(fmt_reg, cur_word);
        new_b.col      = src_col_reg;
        new_b.row      = src_row_reg;
        new_b.fin      = in_data.final_row;
        new_b.last_job = 1'b1;
    end

    // handshake and stage advance
    always_comb
    begin
        e_end   = e_job_reg.fin ? STEP_LAST_COPY : STEP_LAST_EVEN;
        e_done  = e_valid_reg && out_ready && (e_step_reg == e_end);
        f_to_e  = f_valid_reg && (!e_valid_reg || e_done);
        pop     = (a_valid_reg || b_valid_reg) && (!f_valid_reg || f_to_e);
        pop_job = a_valid_reg ? a_job_reg : b_job_reg;
        pop_addr = ADDR_W'(pop_job.col);
        f_start = (f_job_reg.row != '0) ? STEP_FIRST_VERT : STEP_FIRST_EVEN;
        in_ready = !(a_valid_reg && b_valid_reg) &&
                   ((!a_valid_reg && !b_valid_reg) || pop);
        in_fire = in_valid && in_ready;
    end

    // control next state
    always_comb
    begin
        prev_word_next = prev_word_reg;
        have_prev_next = have_prev_reg;
        src_col_next   = src_col_reg;
        src_row_next   = src_row_reg;
        a_valid_next   = a_valid_reg;
        b_valid_next   = b_valid_reg;
        f_valid_next   = f_valid_reg;
        e_valid_next   = e_valid_reg;
        e_step_next    = e_step_reg;

        // source position tracking
        if (in_fire)
        begin
            if (in_data.last_in_row)
            begin
                prev_word_next = '0;
                have_prev_next = 1'b0;
                src_col_next   = '0;
                if (in_data.final_row || row_inc >= ROW_LIMIT)
                    src_row_next = '0;
                else
                    src_row_next = row_inc[ROW_W-1:0];
            end
            else
            begin
                prev_word_next = cur_word;
                have_prev_next = 1'b1;
                src_col_next   = (col_inc >= COL_LIMIT) ? '0 : col_inc[COL_W-1:0];
            end
        end

        // job slots, previous pair before row-end pair
        if (pop)
        begin
            if (a_valid_reg)
                a_valid_next = 1'b0;
            else
                b_valid_next = 1'b0;
        end
        if (in_fire)
        begin
            a_valid_next = have_prev_reg;
            b_valid_next = in_data.last_in_row;
        end

        // fetch stage
        if (pop)
            f_valid_next = 1'b1;
        else if (f_to_e)
            f_valid_next = 1'b0;

        // emit stage
        if (f_to_e)
        begin
            e_valid_next = 1'b1;
            e_step_next  = f_start;
        end
        else if (e_done)
        begin
            e_valid_next = 1'b0;
        end
        else if (e_valid_reg && out_ready)
        begin
            e_step_next = e_step_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_word_reg <= '0;
            have_prev_reg <= 1'b0;
            src_col_reg   <= '0;
            src_row_reg   <= '0;
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            f_valid_reg   <= 1'b0;
            e_valid_reg   <= 1'b0;
            e_step_reg    <= STEP_FIRST_VERT;
        end
        else
        begin
            prev_word_reg <= prev_word_next;
            have_prev_reg <= have_prev_next;
            src_col_reg   <= src_col_next;
            src_row_reg   <= src_row_next;
            a_valid_reg   <= a_valid_next;
            b_valid_reg   <= b_valid_next;
            f_valid_reg   <= f_valid_next;
            e_valid_reg   <= e_valid_next;
            e_step_reg    <= e_step_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            a_job_reg <= new_a;
            b_job_reg <= new_b;
        end
        if (pop)
        begin
            f_job_reg <= pop_job;
        end
        if (f_to_e)
        begin
            e_job_reg <= f_job_reg;
            e_va0_reg <= vert_avg(fmt_reg, ram_rdata[31:0], f_job_reg.ev);
            e_va1_reg <= vert_avg(fmt_reg, ram_rdata[63:32], f_job_reg.od);
        end
    end

    // line store: old pair read and new pair written in the same cycle
    upx2_ram #(
        .WIDTH (64),
        .DEPTH (PAIR_DEPTH)
    ) u_line_store (
        .clk   (clk),
        .we    (pop),
        .waddr (pop_addr),
        .wdata ({pop_job.od, pop_job.ev}),
        .re    (pop),
        .raddr (pop_addr),
        .rdata (ram_rdata)
    );

    // result mux
    logic [1:0]         e_phase;
    logic               e_k;
    logic [COORD_W-1:0] row12;
    logic [COORD_W-1:0] col12;
    logic [COORD_W-1:0] row2;

    always_comb
    begin
        e_phase = e_step_reg[2:1];
        e_k     = e_step_reg[0];
        row12   = COORD_W'(e_job_reg.row);
        col12   = COORD_W'(e_job_reg.col);
        row2    = {row12[COORD_W-2:0], 1'b0};

        out_valid            = e_valid_reg;
        out_data.out_col     = {col12[COORD_W-2:0], e_k};
        out_data.last_of_run = e_job_reg.last_job && (e_step_reg == e_end);
        case (e_phase)
            PH_VERT:
            begin
                out_data.out_word = e_k ? e_va1_reg : e_va0_reg;
                out_data.out_row  = row2 - 1'b1;
            end
            PH_EVEN:
            begin
                out_data.out_word = e_k ? e_job_reg.od : e_job_reg.ev;
                out_data.out_row  = row2;
            end
            PH_COPY:
            begin
                out_data.out_word = e_k ? e_job_reg.od : e_job_reg.ev;
                out_data.out_row  = row2 | 1'b1;
            end
            default:
            begin
                out_data.out_word = e_k ? e_job_reg.od : e_job_reg.ev;
                out_data.out_row  = row2;
            end
        endcase
    end

`ifndef SYNTHESIS
    // both job slots full must hold off new requests
    assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && b_valid_reg) |-> !in_ready)
        else $error("request taken while both job slots are full");

    // source row zero has no interpolated row
    assert property (@(posedge clk) disable iff (!rst_n)
        (e_valid_reg && e_job_reg.row == '0) |-> (e_step_reg >= STEP_FIRST_EVEN))
        else $error("interpolated row emitted for source row zero");

    // copy row only after the final source row
    assert property (@(posedge clk) disable iff (!rst_n)
        (e_valid_reg && !e_job_reg.fin) |-> (e_step_reg <= STEP_LAST_EVEN))
        else $error("copy row emitted outside the final row");

    // a line store read always lands in the fetch stage
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> f_valid_reg)
        else $error("line store read without fetch stage valid");

    // emit stage starts at the right step after a load
    assert property (@(posedge clk) disable iff (!rst_n)
        f_to_e |=> (e_valid_reg && (e_step_reg == STEP_FIRST_VERT
                                    || e_step_reg == STEP_FIRST_EVEN)))
        else $error("emit stage loaded with a bad start step");
`endif

endmodule
